>>> design/rpfd_pkg.sv
// Package for the radix-r fixed-point divider.
// Holds field widths, register map and radix limits; no dependencies.
package rpfd_pkg;

    localparam int MANT_W     = 24;
    localparam int SCALE_W    = 3;
    localparam int RADIX_W    = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // Register index, taken from paddr word bit
    localparam logic REG_RADIX = 1'b0;

endpackage

>>> design/rpfd_if.sv
// Stream interfaces for the radix-r fixed-point divider: operand and quotient digit beats.
// Depends on rpfd_pkg.
interface rpfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [rpfd_pkg::MANT_W-1:0]   dividend_mantissa;
    logic [rpfd_pkg::SCALE_W-1:0]  dividend_scale;
    logic [rpfd_pkg::MANT_W-1:0]   divisor_mantissa;
    logic [rpfd_pkg::SCALE_W-1:0]  divisor_scale;

    modport source (output valid, dividend_mantissa, dividend_scale,
                    divisor_mantissa, divisor_scale, input ready);
    modport sink   (input valid, dividend_mantissa, dividend_scale,
                    divisor_mantissa, divisor_scale, output ready);
endinterface

interface rpfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [rpfd_pkg::RADIX_W-1:0]  digit;
    logic                          in_fraction;
    logic                          div_error;
    logic                          last;

    modport source (output valid, digit, in_fraction, div_error, last, input ready);
    modport sink   (input valid, digit, in_fraction, div_error, last, output ready);
endinterface

>>> design/radix_p_fixed_point_divider.sv
// Operation: scale both operands, run the main division, peel off the integer digits by
// repeated division by the radix, then form each fractional digit by a short division;
// each digit leaves as one output beat, and a zero divisor gives a single error beat.
// One division at a time: the next operand beat is taken in the cycle after the last beat
// leaves, so the shared restoring divider (one bit per cycle) sets the rate.
// Reset (rst_n, asynchronous, active low) sets the radix to 10 and returns to idle.
module radix_p_fixed_point_divider #(
    parameter int FRAC_DIGITS = 9,
    parameter int MANT_BITS   = 24,
    parameter int MAX_SCALE   = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rpfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rpfd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    rpfd_in_if.sink                       operands,
    rpfd_out_if.source                    quotient
);
    import rpfd_pkg::*;

    localparam int POW_W  = $clog2(36 ** MAX_SCALE + 1);
    localparam int PROD_W = MANT_BITS + POW_W;
    localparam int MUL_W  = PROD_W + RADIX_W;
    localparam int IT_W   = $clog2(PROD_W + 1);
    localparam int AW     = $clog2(PROD_W);
    localparam int FC_W   = $clog2(FRAC_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE, S_DIV, S_POST, S_IREAD, S_ILOAD, S_OUT, S_FMUL
    } state_t;

    typedef enum logic [1:0] {PH_MAIN, PH_INT, PH_FRAC} phase_t;

    state_t               state_reg;
    phase_t               phase_reg;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   r_reg;
    logic [PROD_W-1:0]    num_reg;
    logic [PROD_W-1:0]    den_reg;
    logic [PROD_W-1:0]    rem_reg;
    logic [SCALE_W-1:0]   cnt_v_reg;
    logic [SCALE_W-1:0]   cnt_d_reg;
    logic [PROD_W-1:0]    p_reg;
    logic [PROD_W-1:0]    x_reg;
    logic [PROD_W-1:0]    d_reg;
    logic [IT_W-1:0]      it_reg;
    logic [IT_W-1:0]      nint_reg;
    logic [AW-1:0]        idx_reg;
    logic [FC_W-1:0]      fcnt_reg;
    logic                 out_valid_reg;
    logic [RADIX_W-1:0]   out_digit_reg;
    logic                 out_frac_reg;
    logic                 out_err_reg;
    logic                 out_last_reg;

    logic [RADIX_W-1:0]   stack_mem [PROD_W];
    logic [RADIX_W-1:0]   rd_reg;

    logic [RADIX_W-1:0]   wr_val;
    logic [SCALE_W-1:0]   ds_clamp;
    logic [SCALE_W-1:0]   vs_clamp;
    logic [PROD_W-1:0]    mul_a;
    logic [MUL_W-1:0]     mul_p;
    logic [PROD_W:0]      div_t;
    logic [PROD_W:0]      div_diff;
    logic                 div_ge;
    logic                 stack_we;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = PDATA_W'(radix_reg);
    assign wr_val = pwdata[RADIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX))
        begin
            priority if (wr_val < RADIX_MIN)
                radix_reg <= RADIX_MIN;
            else if (wr_val > RADIX_MAX)
                radix_reg <= RADIX_MAX;
            else
                radix_reg <= wr_val;
        end
    end

    // ---------------- shared datapath ----------------
    assign ds_clamp = (operands.dividend_scale > SCALE_W'(MAX_SCALE)) ?
                      SCALE_W'(MAX_SCALE) : operands.dividend_scale;
    assign vs_clamp = (operands.divisor_scale > SCALE_W'(MAX_SCALE)) ?
                      SCALE_W'(MAX_SCALE) : operands.divisor_scale;

    always_comb
    begin
        priority if (state_reg == S_FMUL)
            mul_a = rem_reg;
        else if (cnt_v_reg != '0)
            mul_a = num_reg;
        else
            mul_a = den_reg;
    end

    assign mul_p    = MUL_W'(mul_a) * MUL_W'(r_reg);

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign div_t    = {p_reg, x_reg[PROD_W-1]};
    assign div_diff = div_t - {1'b0, d_reg};
    assign div_ge   = (div_t >= {1'b0, d_reg});

    assign operands.ready       = (state_reg == S_IDLE);
    assign quotient.valid       = out_valid_reg;
    assign quotient.digit       = out_digit_reg;
    assign quotient.in_fraction = out_frac_reg;
    assign quotient.div_error   = out_err_reg;
    assign quotient.last        = out_last_reg;

    assign stack_we = (state_reg == S_POST) && (phase_reg == PH_INT);

    // Integer digit stack, emitted in reverse order
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[nint_reg[AW-1:0]] <= p_reg[RADIX_W-1:0];
        if (state_reg == S_IREAD)
            rd_reg <= stack_mem[idx_reg];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_MAIN;
            out_valid_reg <= 1'b0;
            it_reg        <= '0;
            nint_reg      <= '0;
            idx_reg       <= '0;
            fcnt_reg      <= '0;
            cnt_v_reg     <= '0;
            cnt_d_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (operands.valid)
                    begin
                        r_reg     <= radix_reg;
                        num_reg   <= PROD_W'(operands.dividend_mantissa[MANT_BITS-1:0]);
                        den_reg   <= PROD_W'(operands.divisor_mantissa[MANT_BITS-1:0]);
                        cnt_v_reg <= vs_clamp;
                        cnt_d_reg <= ds_clamp;
                        fcnt_reg  <= '0;
                        phase_reg <= PH_MAIN;
                        if (operands.divisor_mantissa[MANT_BITS-1:0] == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            out_digit_reg <= '0;
                            out_frac_reg  <= 1'b0;
                            out_err_reg   <= 1'b1;
                            out_last_reg  <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_SCALE;
                        end
                    end
                end

                // Bring both operands to a common scale
                S_SCALE:
                begin
                    priority if (cnt_v_reg != '0)
                    begin
                        num_reg   <= mul_p[PROD_W-1:0];
                        cnt_v_reg <= cnt_v_reg - 1'b1;
                    end
                    else if (cnt_d_reg != '0)
                    begin
                        den_reg   <= mul_p[PROD_W-1:0];
                        cnt_d_reg <= cnt_d_reg - 1'b1;
                    end
                    else
                    begin
                        p_reg     <= '0;
                        x_reg     <= num_reg;
                        d_reg     <= den_reg;
                        it_reg    <= IT_W'(PROD_W);
                        phase_reg <= PH_MAIN;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    p_reg  <= div_ge ? div_diff[PROD_W-1:0] : div_t[PROD_W-1:0];
                    x_reg  <= {x_reg[PROD_W-2:0], div_ge};
                    it_reg <= it_reg - 1'b1;
                    if (it_reg == IT_W'(1))
                        state_reg <= S_POST;
                end

                S_POST:
                begin
                    unique case (phase_reg)
                        PH_MAIN:
                        begin
                            // Quotient stays in x; peel off radix digits from it
                            rem_reg   <= p_reg;
                            p_reg     <= '0;
                            d_reg     <= PROD_W'(r_reg);
                            it_reg    <= IT_W'(PROD_W);
                            nint_reg  <= '0;
                            phase_reg <= PH_INT;
                            state_reg <= S_DIV;
                        end
                        PH_INT:
                        begin
                            nint_reg <= nint_reg + 1'b1;
                            if (x_reg == '0)
                            begin
                                idx_reg   <= nint_reg[AW-1:0];
                                state_reg <= S_IREAD;
                            end
                            else
                            begin
                                p_reg     <= '0;
                                it_reg    <= IT_W'(PROD_W);
                                state_reg <= S_DIV;
                            end
                        end
                        PH_FRAC:
                        begin
                            rem_reg       <= p_reg;
                            fcnt_reg      <= fcnt_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_digit_reg <= x_reg[RADIX_W-1:0];
                            out_frac_reg  <= 1'b1;
                            out_err_reg   <= 1'b0;
                            out_last_reg  <= (fcnt_reg == FC_W'(FRAC_DIGITS - 1));
                            state_reg     <= S_OUT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_IREAD:
                begin
                    state_reg <= S_ILOAD;
                end

                S_ILOAD:
                begin
                    out_valid_reg <= 1'b1;
                    out_digit_reg <= rd_reg;
                    out_frac_reg  <= 1'b0;
                    out_err_reg   <= 1'b0;
                    out_last_reg  <= 1'b0;
                    state_reg     <= S_OUT;
                end

                S_OUT:
                begin
                    if (quotient.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        priority if (out_last_reg)
                            state_reg <= S_IDLE;
                        else if ((phase_reg == PH_INT) && (idx_reg != '0))
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_IREAD;
                        end
                        else
                            state_reg <= S_FMUL;
                    end
                end

                // Next fraction digit: divide rem*r by den, quotient fits in RADIX_W bits
                S_FMUL:
                begin
                    p_reg     <= mul_p[MUL_W-1:RADIX_W];
                    x_reg     <= {mul_p[RADIX_W-1:0], {(PROD_W-RADIX_W){1'b0}}};
                    d_reg     <= den_reg;
                    it_reg    <= IT_W'(RADIX_W);
                    phase_reg <= PH_FRAC;
                    state_reg <= S_DIV;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        operands.ready |-> !quotient.valid)
        else $error("output beat pending while accepting operands");

    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (quotient.valid && quotient.div_error) |-> (quotient.last && quotient.digit == '0))
        else $error("error beat malformed");

    a_int_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (quotient.valid && !quotient.in_fraction && !quotient.div_error) |-> !quotient.last)
        else $error("integer digit flagged last");

    a_div_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg != '0 && p_reg < d_reg))
        else $error("divider partial remainder out of range");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        quotient.valid |-> (quotient.digit < r_reg || quotient.div_error))
        else $error("digit not below radix");
`endif

endmodule
